// ----- rtl/bgc_pkg.sv -----
// shared types and constants for the box grid cell cover block
// no dependencies; used by the interfaces, the divider and the core

package bgc_pkg;

  localparam int BOX_W      = 32;  // corner coordinate width, signed
  localparam int PT_W       = 30;  // sample point width, unsigned
  localparam int SP_W       = 20;  // tile spacing width
  localparam int TILES_W    = 11;  // tile count width
  localparam int EPS_W      = 8;   // border margin width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int DIV_W      = 31;  // dividend and quotient width
  localparam int DIV_STEP_W = 5;

  localparam logic [PT_W-1:0] PT_MAX = {PT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_DOWN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON      = 3'd4;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [SP_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/bgc_ifs.sv -----
// channel interfaces for the box grid cell cover block
// depends on bgc_pkg for field widths

interface bgc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [bgc_pkg::BOX_W-1:0]    box_x_low;
  logic signed [bgc_pkg::BOX_W-1:0]    box_y_low;
  logic signed [bgc_pkg::BOX_W-1:0]    box_x_high;
  logic signed [bgc_pkg::BOX_W-1:0]    box_y_high;

  modport source (output valid, box_x_low, box_y_low, box_x_high, box_y_high,
                  input ready);
  modport sink (input valid, box_x_low, box_y_low, box_x_high, box_y_high,
                output ready);
endinterface

interface bgc_out_if;
  logic                      valid;
  logic                      ready;
  logic [bgc_pkg::PT_W-1:0]  point_x;
  logic [bgc_pkg::PT_W-1:0]  point_y;
  logic                      last_point;
  logic                      empty_box;
  logic                      span_clipped;

  modport source (output valid, point_x, point_y, last_point, empty_box, span_clipped,
                  input ready);
  modport sink (input valid, point_x, point_y, last_point, empty_box, span_clipped,
                output ready);
endinterface

// ----- rtl/bgc_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on bgc_pkg for the request and response structs

module bgc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  bgc_pkg::div_req_t req,
  output bgc_pkg::div_rsp_t rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [bgc_pkg::DIV_STEP_W-1:0] step_r;
  logic [bgc_pkg::SP_W-1:0]       rem_r;
  logic [bgc_pkg::SP_W-1:0]       dvs_r;
  logic [bgc_pkg::DIV_W-1:0]      quo_r;

  logic [bgc_pkg::SP_W:0]         rem_sh;
  logic [bgc_pkg::SP_W:0]         rem_sub;
  logic                           ge;
  logic [bgc_pkg::SP_W-1:0]       rem_nxt;

  assign rem_sh  = {rem_r, quo_r[bgc_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign rem_nxt = ge ? rem_sub[bgc_pkg::SP_W-1:0] : rem_sh[bgc_pkg::SP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= req.dividend;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[bgc_pkg::DIV_W-2:0], ge};
      step_r <= step_r + bgc_pkg::DIV_STEP_W'(1);
      if (step_r == bgc_pkg::DIV_STEP_W'(bgc_pkg::DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- rtl/box_grid_cell_cover_core.sv -----
// box grid cell cover: clips a rectangle to the tiled plane and walks its cells
// depends on bgc_pkg, bgc_ifs (channel interfaces) and bgc_div
//
//   port      direction  contents
//   in_ch     sink       box_x_low, box_y_low, box_x_high, box_y_high (signed)
//   out_ch    source     point_x, point_y, last_point, empty_box, span_clipped
//   cfg_*     write      cfg_we, cfg_index, cfg_wdata (no read-back)
//
// one rectangle at a time: in_ch.ready is high only while the core is idle
// per axis: multiply, clip and shrink states, then two divisions on the shared
// divider (skipped for a collapsed axis); after both axes the words follow,
// one word per cycle while out_ch.ready holds
// an inverted or off-plane box skips straight to a single empty word
// synchronous active-low reset; control state cleared, payload registers are not

module box_grid_cell_cover_core #(
  parameter int MAX_SPAN = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bgc_in_if.sink                             in_ch,
  bgc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_SPAN + 1);
  localparam int AW    = 34;  // working width for signed clip arithmetic

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CLIP, S_SPAN, S_DIVS, S_DIVE, S_LOAD, S_EMIT
  } state_t;

  // configuration registers
  logic [bgc_pkg::SP_W-1:0]    tile_width_r;
  logic [bgc_pkg::SP_W-1:0]    tile_height_r;
  logic [bgc_pkg::TILES_W-1:0] tiles_across_r;
  logic [bgc_pkg::TILES_W-1:0] tiles_down_r;
  logic [bgc_pkg::EPS_W-1:0]   epsilon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_width_r   <= bgc_pkg::SP_W'(256);
      tile_height_r  <= bgc_pkg::SP_W'(256);
      tiles_across_r <= bgc_pkg::TILES_W'(64);
      tiles_down_r   <= bgc_pkg::TILES_W'(64);
      epsilon_r      <= bgc_pkg::EPS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bgc_pkg::CFG_TILE_WIDTH:   tile_width_r   <= cfg_wdata;
        bgc_pkg::CFG_TILE_HEIGHT:  tile_height_r  <= cfg_wdata;
        bgc_pkg::CFG_TILES_ACROSS: tiles_across_r <= cfg_wdata[bgc_pkg::TILES_W-1:0];
        bgc_pkg::CFG_TILES_DOWN:   tiles_down_r   <= cfg_wdata[bgc_pkg::TILES_W-1:0];
        bgc_pkg::CFG_EPSILON:      epsilon_r      <= cfg_wdata[bgc_pkg::EPS_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // control and working registers
  state_t                          state_r;
  logic                            ax_r;        // 0 = x axis, 1 = y axis
  logic signed [bgc_pkg::BOX_W-1:0] bx_lo_r, by_lo_r, bx_hi_r, by_hi_r;
  logic [30:0]                     prod_r;      // spacing * tiles
  logic signed [AW-1:0]            lo_r, hi_r;  // clipped axis bounds
  logic [bgc_pkg::DIV_W-1:0]       e_r;         // shrunk end, second dividend
  logic [bgc_pkg::DIV_W-1:0]       qs_r;        // start / spacing
  logic [bgc_pkg::PT_W-1:0]        sx_r, sy_r;  // saturated axis start points
  logic [CNT_W-1:0]                cntx_r, cnty_r;
  logic                            clipped_r;
  logic                            empty_r;
  logic                            out_valid_r;

  // cell walk registers
  logic [bgc_pkg::PT_W-1:0]        row_start_x_r, cursor_x_r, cursor_y_r;
  logic [CNT_W-1:0]                cols_total_r, cols_left_r, rows_left_r;

  // zero spacing behaves as one
  logic [bgc_pkg::SP_W-1:0] sp_x, sp_y, sp_ax;
  logic [bgc_pkg::TILES_W-1:0] tiles_ax;
  assign sp_x     = (tile_width_r  == '0) ? bgc_pkg::SP_W'(1) : tile_width_r;
  assign sp_y     = (tile_height_r == '0) ? bgc_pkg::SP_W'(1) : tile_height_r;
  assign sp_ax    = ax_r ? sp_y : sp_x;
  assign tiles_ax = ax_r ? tiles_down_r : tiles_across_r;

  // plane extent product, registered before use
  logic [30:0] mul_full;
  assign mul_full = {11'b0, sp_ax} * {20'b0, tiles_ax};

  // clip stage, shared by both axes
  logic signed [AW-1:0] eps_s, pmax, lo_ext, hi_ext, lo_c, hi_c;
  logic                 lo_neg, lo_gt, hi_neg, hi_gt, off_plane;
  assign eps_s  = $signed({{(AW-bgc_pkg::EPS_W){1'b0}}, epsilon_r});
  assign pmax   = $signed({{(AW-31){1'b0}}, prod_r}) - eps_s;
  assign lo_ext = ax_r ? AW'(by_lo_r) : AW'(bx_lo_r);
  assign hi_ext = ax_r ? AW'(by_hi_r) : AW'(bx_hi_r);
  assign lo_neg = lo_ext[AW-1];
  assign hi_neg = hi_ext[AW-1];
  assign lo_gt  = lo_ext > pmax;
  assign hi_gt  = hi_ext > pmax;
  // the off-plane test on each bound applies only where that bound was not clamped
  assign off_plane = (!lo_neg && lo_gt) || (!hi_gt && hi_neg);
  assign lo_c   = lo_neg ? '0 : lo_ext;
  assign hi_c   = hi_gt ? pmax : hi_ext;

  // shrink stage: start, end, collapse to midpoint
  logic signed [AW-1:0] s_v, e_v, sum_v, mid_v, start_v;
  logic                 collapse;
  assign s_v      = lo_r + eps_s;
  assign e_v      = hi_r - eps_s;
  assign collapse = e_v < s_v;
  assign sum_v    = lo_r + hi_r;
  assign mid_v    = sum_v >>> 1;  // floor toward minus infinity
  assign start_v  = collapse ? mid_v : s_v;

  function automatic logic [bgc_pkg::PT_W-1:0] sat_pt(input logic signed [AW-1:0] v);
    if (v[AW-1])
      return '0;
    else if (v > $signed({{(AW-bgc_pkg::PT_W){1'b0}}, bgc_pkg::PT_MAX}))
      return bgc_pkg::PT_MAX;
    else
      return v[bgc_pkg::PT_W-1:0];
  endfunction

  // shared divider
  bgc_pkg::div_req_t div_req;
  bgc_pkg::div_rsp_t div_rsp;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = s_v[bgc_pkg::DIV_W-1:0];
    div_req.divisor  = sp_ax;
    if (state_r == S_SPAN && !collapse) begin
      div_req.start = 1'b1;
    end else if (state_r == S_DIVS && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = e_r;
    end
  end

  bgc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // cell count from the two quotients, saturated
  logic [bgc_pkg::DIV_W-1:0] q_diff;
  logic                      q_sat;
  logic [CNT_W-1:0]          cnt_v;
  assign q_diff = div_rsp.quotient - qs_r;
  assign q_sat  = q_diff >= bgc_pkg::DIV_W'(MAX_SPAN);
  assign cnt_v  = q_sat ? CNT_W'(MAX_SPAN) : CNT_W'(q_diff + bgc_pkg::DIV_W'(1));

  // stepping with saturation at the top of the point range
  logic [bgc_pkg::PT_W:0]   cx_add, cy_add;
  logic [bgc_pkg::PT_W-1:0] cx_step, cy_step;
  logic                     last_w;
  assign cx_add  = {1'b0, cursor_x_r} + {{(bgc_pkg::PT_W+1-bgc_pkg::SP_W){1'b0}}, sp_x};
  assign cy_add  = {1'b0, cursor_y_r} + {{(bgc_pkg::PT_W+1-bgc_pkg::SP_W){1'b0}}, sp_y};
  assign cx_step = cx_add[bgc_pkg::PT_W] ? bgc_pkg::PT_MAX : cx_add[bgc_pkg::PT_W-1:0];
  assign cy_step = cy_add[bgc_pkg::PT_W] ? bgc_pkg::PT_MAX : cy_add[bgc_pkg::PT_W-1:0];
  assign last_w  = (rows_left_r == CNT_W'(1)) && (cols_left_r == CNT_W'(1));

  logic in_fire, out_fire;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ax_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      empty_r       <= 1'b0;
      clipped_r     <= 1'b0;
      row_start_x_r <= '0;
      cursor_x_r    <= '0;
      cursor_y_r    <= '0;
      cols_total_r  <= '0;
      cols_left_r   <= '0;
      rows_left_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            bx_lo_r   <= in_ch.box_x_low;
            by_lo_r   <= in_ch.box_y_low;
            bx_hi_r   <= in_ch.box_x_high;
            by_hi_r   <= in_ch.box_y_high;
            ax_r      <= 1'b0;
            clipped_r <= 1'b0;
            if ((in_ch.box_x_low > in_ch.box_x_high) ||
                (in_ch.box_y_low > in_ch.box_y_high)) begin
              // inverted box: single empty word
              row_start_x_r <= '0;
              cursor_x_r    <= '0;
              cursor_y_r    <= '0;
              cols_total_r  <= CNT_W'(1);
              cols_left_r   <= CNT_W'(1);
              rows_left_r   <= CNT_W'(1);
              empty_r       <= 1'b1;
              out_valid_r   <= 1'b1;
              state_r       <= S_EMIT;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= mul_full;
          state_r <= S_CLIP;
        end
        S_CLIP: begin
          if (off_plane) begin
            row_start_x_r <= '0;
            cursor_x_r    <= '0;
            cursor_y_r    <= '0;
            cols_total_r  <= CNT_W'(1);
            cols_left_r   <= CNT_W'(1);
            rows_left_r   <= CNT_W'(1);
            empty_r       <= 1'b1;
            clipped_r     <= 1'b0;
            out_valid_r   <= 1'b1;
            state_r       <= S_EMIT;
          end else begin
            lo_r    <= lo_c;
            hi_r    <= hi_c;
            state_r <= S_SPAN;
          end
        end
        S_SPAN: begin
          if (ax_r) sy_r <= sat_pt(start_v);
          else      sx_r <= sat_pt(start_v);
          if (collapse) begin
            // too narrow after shrink: one cell at the midpoint
            if (ax_r) begin
              cnty_r  <= CNT_W'(1);
              state_r <= S_LOAD;
            end else begin
              cntx_r  <= CNT_W'(1);
              ax_r    <= 1'b1;
              state_r <= S_MUL;
            end
          end else begin
            e_r     <= e_v[bgc_pkg::DIV_W-1:0];
            state_r <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (div_rsp.done) begin
            qs_r    <= div_rsp.quotient;
            state_r <= S_DIVE;
          end
        end
        S_DIVE: begin
          if (div_rsp.done) begin
            if (q_sat) clipped_r <= 1'b1;
            if (ax_r) begin
              cnty_r  <= cnt_v;
              state_r <= S_LOAD;
            end else begin
              cntx_r  <= cnt_v;
              ax_r    <= 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_LOAD: begin
          row_start_x_r <= sx_r;
          cursor_x_r    <= sx_r;
          cursor_y_r    <= sy_r;
          cols_total_r  <= cntx_r;
          cols_left_r   <= cntx_r;
          rows_left_r   <= cnty_r;
          empty_r       <= 1'b0;
          out_valid_r   <= 1'b1;
          state_r       <= S_EMIT;
        end
        S_EMIT: begin
          if (out_fire) begin
            if (last_w) begin
              out_valid_r <= 1'b0;
              state_r     <= S_IDLE;
            end else if (cols_left_r == CNT_W'(1)) begin
              // end of row: back to the row start, one spacing down
              cols_left_r <= cols_total_r;
              rows_left_r <= rows_left_r - CNT_W'(1);
              cursor_x_r  <= row_start_x_r;
              cursor_y_r  <= cy_step;
            end else begin
              cols_left_r <= cols_left_r - CNT_W'(1);
              cursor_x_r  <= cx_step;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.point_x      = cursor_x_r;
  assign out_ch.point_y      = cursor_y_r;
  assign out_ch.last_point   = last_w;
  assign out_ch.empty_box    = empty_r;
  assign out_ch.span_clipped = clipped_r;

endmodule
